@@ rtl/isc_pkg.sv @@
//------------------------------------------------------------------------------
// isc_pkg
// Shared types and constants of the inductive steering PD controller.
//------------------------------------------------------------------------------
package isc_pkg;
	localparam int FRAC_BITS_DEF = 14;
	localparam int HIST_DEPTH_DEF = 4;
	localparam int SENSE_W = 13;
	localparam int DRIVE_W = 18;
	localparam int NUM_REGS = 8;
	localparam int ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_MAIN_P = 3'd0, REG_MAIN_D = 3'd1, REG_ROUND_P = 3'd2, REG_ROUND_D = 3'd3,
		REG_TURN = 3'd4, REG_FREEZE = 3'd5, REG_DOWN = 3'd6, REG_GARAGE = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] main_p;
		logic [15:0] main_d;
		logic [15:0] round_p;
		logic [15:0] round_d;
		logic [15:0] turn;
		logic [15:0] freeze;
		logic [15:0] down;
		logic [13:0] garage;
	} cfg_t;

	typedef struct packed {
		logic [SENSE_W-1:0] sense_h_left;
		logic [SENSE_W-1:0] sense_h_right;
		logic [SENSE_W-1:0] sense_v_left;
		logic [SENSE_W-1:0] sense_v_right;
	} in_item_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] steer_drive;
		logic round_active;
		logic leave_pending;
		logic stop_request;
		logic garage_lamp;
		logic green_lamp;
		logic red_lamp;
	} out_item_t;
endpackage

@@ rtl/isc_if.sv @@
//------------------------------------------------------------------------------
// isc_if
// Valid/ready channel carrying one payload item.
//------------------------------------------------------------------------------
interface isc_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/inductive_steering_pd_controller_core.sv @@
// Each transaction runs through two serial divisions (one quotient bit per cycle over
// FRAC_BITS+14 bits, plus start and finish) and two passes of the shift-add gain
// multiplier over the 16 gain bits; only one transaction is in flight at a time.
// A new transaction is taken as soon as the previous result sits in the output register.
// Reset (arst_n low) clears history, mode counters, lamps; down counter loads 100.
//------------------------------------------------------------------------------
// inductive_steering_pd_controller_core
// Steering PD controller with garage, stop and roundabout logic, serial datapath.
//------------------------------------------------------------------------------
module inductive_steering_pd_controller_core #(
	parameter int FRAC_BITS = isc_pkg::FRAC_BITS_DEF,
	parameter int HIST_DEPTH = isc_pkg::HIST_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	isc_if.sink in_ch,
	isc_if.source out_ch,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [isc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import isc_pkg::*;
	localparam int NUM_W = FRAC_BITS + 14;
	localparam int EW = FRAC_BITS + 2;
	localparam logic signed [EW-1:0] DLIM = EW'((7 << FRAC_BITS) / 10);
	localparam int AW = EW + 19;

	typedef enum logic [2:0] {S_IDLE, S_DIV_H, S_DIV_V, S_MUL_P, S_MUL_D, S_OUT} st_t;
	st_t st_q;
	cfg_t cfg;
	in_item_t in_q;
	logic [13:0] s0, s1, s2, s3;
	logic signed [EW-1:0] hist_h_q [HIST_DEPTH];
	logic signed [EW-1:0] hist_v_q [HIST_DEPTH];
	logic signed [EW-1:0] eh_q, ev_q, dh_q, dv_q;
	logic [1:0] garage_q;
	logic round_q, leave_q, stop_q;
	logic [15:0] turn_q, freeze_q, down_q;
	logic [4:0] blink_q;
	logic [2:0] lamp_q;
	logic div_start, div_done, div_neg;
	logic [NUM_W-1:0] div_num;
	logic [13:0] div_den;
	logic signed [NUM_W:0] div_quot;
	logic [15:0] mgain_q;
	logic signed [EW-1:0] mop_q;
	logic signed [AW-1:0] acc_q;
	logic [4:0] mcnt_q;
	logic out_v_q;
	out_item_t out_q;
	logic [13:0] da, db;
	logic signed [EW-1:0] en;
	logic signed [EW+3:0] dfull;
	logic signed [EW-1:0] dcl;
	logic signed [AW-1:0] shr;
	logic out_fire;

	isc_regs u_regs (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg);

	// Scaling by nine tenths (readings below 10 taken as 10) through a reciprocal multiply, exact for the reading range.
	function automatic logic [13:0] scale(input logic [12:0] v);
		logic [12:0] c;
		logic [32:0] p;
		c = (v < 13'd10) ? 13'd10 : v;
		p = 33'(17'(c) * 17'd9) * 33'd52429;
		return p[32:19];
	endfunction

	assign s0 = scale(in_q.sense_h_left);
	assign s1 = scale(in_q.sense_h_right);
	assign s2 = scale(in_q.sense_v_left);
	assign s3 = scale(in_q.sense_v_right);
	assign da = (st_q == S_DIV_H || st_q == S_IDLE) ? s0 : s2;
	assign db = (st_q == S_DIV_H || st_q == S_IDLE) ? s1 : s3;
	assign div_neg = da < db;
	assign div_num = NUM_W'(div_neg ? db - da : da - db) << FRAC_BITS;
	assign div_den = da + db;

	isc_div #(.NUM_W(NUM_W), .DEN_W(14)) u_div (.clk, .arst_n, .start(div_start),
		.neg(div_neg), .num(div_num), .den(div_den), .done(div_done), .quot(div_quot));

	assign en = EW'(div_quot);
	assign dfull = 5 * ((EW+4)'(en) - (EW+4)'(st_q == S_DIV_H ? hist_h_q[HIST_DEPTH-2]
		: hist_v_q[HIST_DEPTH-2]));
	assign dcl = (dfull > (EW+4)'(DLIM)) ? DLIM : (dfull < -(EW+4)'(DLIM)) ? -DLIM
		: EW'(dfull);
	assign shr = acc_q >>> FRAC_BITS;
	assign out_fire = (st_q == S_OUT) && (!out_v_q || out_ch.ready);
	assign in_ch.ready = (st_q == S_IDLE);
	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_q;

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) in_q <= in_ch.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic [1:0] g;
		logic [2:0] lb;
		logic rf, lf;
		logic [15:0] tl, fl, dl;
		logic [4:0] bd;
		logic ent, lvc;
		if (!arst_n) begin
			st_q <= S_IDLE;
			div_start <= 1'b0;
			out_v_q <= 1'b0;
			garage_q <= '0; round_q <= 1'b0; leave_q <= 1'b0;
			turn_q <= '0; freeze_q <= '0; down_q <= 16'd100;
			blink_q <= '0; lamp_q <= '0;
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_h_q[i] <= '0;
				hist_v_q[i] <= '0;
			end
		end else begin
			div_start <= (st_q == S_IDLE && in_ch.valid && in_ch.ready)
				|| (st_q == S_DIV_H && div_done);
			if (out_fire) out_v_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready) out_v_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (in_ch.valid && in_ch.ready) begin
					st_q <= S_DIV_H;
				end
				S_DIV_H: if (div_done) begin
					eh_q <= en; dh_q <= dcl;
					for (int i = HIST_DEPTH - 1; i > 0; i--) hist_h_q[i] <= hist_h_q[i-1];
					hist_h_q[0] <= en;
					st_q <= S_DIV_V;
				end
				S_DIV_V: if (div_done) begin
					ev_q <= en; dv_q <= dcl;
					for (int i = HIST_DEPTH - 1; i > 0; i--) hist_v_q[i] <= hist_v_q[i-1];
					hist_v_q[0] <= en;
					// Mode and lamp update for this tick.
					g = garage_q; lb = lamp_q; rf = round_q; lf = leave_q;
					tl = turn_q; fl = freeze_q; dl = down_q; bd = blink_q;
					stop_q <= in_q.sense_h_left < 13'd300 && in_q.sense_h_right < 13'd300
						&& g > 2'd1;
					if (14'(in_q.sense_v_left) + 14'(in_q.sense_v_right) < cfg.garage
						&& 14'(in_q.sense_v_left) + 14'(in_q.sense_v_right) > 14'd25
						&& g == 2'd0) begin
						g = 2'd1; lb[0] = 1'b1;
					end
					if (in_q.sense_h_left > 13'd1000 && in_q.sense_h_right > 13'd1000
						&& g == 2'd1) begin
						g = 2'd2; lb[0] = 1'b0;
					end
					ent = s0 > 14'd2000 && s1 > 14'd2000 && (s2 > 14'd1200 || s3 > 14'd1200)
						&& fl == 16'd0;
					lvc = s0 > 14'd1300 && s1 > 14'd1300 && (s2 > 14'd1000 || s3 > 14'd1000)
						&& fl == 16'd0;
					if (ent) begin
						if (!lf) begin
							rf = 1'b1; lf = 1'b1; lb[1] = 1'b1;
							tl = cfg.turn; fl = cfg.freeze;
						end
					end else if (lvc && lf) begin
						lf = 1'b0; lb[2] = 1'b1; fl = cfg.freeze;
					end
					if (s0 < 14'd2000 && s1 < 14'd2000 && s2 > 14'd1000 && s3 > 14'd1000
						&& dl == 16'd0 && fl == 16'd0 && !lf)
						dl = cfg.down;
					if (dl != 16'd0) begin
						if (bd != 5'd0) bd = bd - 5'd1;
						else begin
							bd = 5'd30; lb[2] = ~lb[2];
						end
						dl = dl - 16'd1;
						if (dl == 16'd0) lb[2] = 1'b0;
					end
					if (fl != 16'd0) begin
						fl = fl - 16'd1;
						if (fl == 16'd0) lb[2:1] = 2'b00;
					end
					if (tl != 16'd0) begin
						tl = tl - 16'd1;
						if (tl == 16'd0) rf = 1'b0;
					end
					garage_q <= g; lamp_q <= lb; round_q <= rf; leave_q <= lf;
					turn_q <= tl; freeze_q <= fl; down_q <= dl; blink_q <= bd;
					acc_q <= '0;
					mgain_q <= rf ? cfg.round_p : cfg.main_p;
					mop_q <= rf ? en : eh_q;
					mcnt_q <= 5'd16;
					st_q <= S_MUL_P;
				end
				S_MUL_P, S_MUL_D: begin
					// Shift-add: one gain bit per cycle, LSB first.
					if (mgain_q[0]) acc_q <= acc_q + (AW'(mop_q) <<< (5'd16 - mcnt_q));
					if (mcnt_q == 5'd1 && st_q == S_MUL_P) begin
						mgain_q <= round_q ? cfg.round_d : cfg.main_d;
						mop_q <= round_q ? dv_q : dh_q;
						mcnt_q <= 5'd16;
						st_q <= S_MUL_D;
					end else begin
						mgain_q <= mgain_q >> 1;
						mcnt_q <= mcnt_q - 5'd1;
						if (mcnt_q == 5'd1) st_q <= S_OUT;
					end
				end
				S_OUT: if (out_fire) begin
					out_q.steer_drive <= (shr > AW'(131071)) ? 18'sd131071 :
						(shr < -AW'(131072)) ? -18'sd131072 : DRIVE_W'(shr);
					out_q.round_active <= round_q;
					out_q.leave_pending <= leave_q;
					out_q.stop_request <= stop_q;
					out_q.garage_lamp <= lamp_q[0];
					out_q.green_lamp <= lamp_q[1];
					out_q.red_lamp <= lamp_q[2];
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	ap_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> st_q == S_IDLE) else $error("ready outside idle");
	ap_garage: assert property (@(posedge clk) disable iff (!arst_n)
		garage_q != 2'd3) else $error("bad garage stage");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(out_q)) else $error("result changed");
	ap_blink: assert property (@(posedge clk) disable iff (!arst_n)
		blink_q <= 5'd30) else $error("blink divider overrun");
endmodule

@@ rtl/isc_div.sv @@
//------------------------------------------------------------------------------
// isc_div
// Bit-serial restoring divider, one quotient bit per cycle, with sign.
//------------------------------------------------------------------------------
module isc_div #(
	parameter int NUM_W = 28,
	parameter int DEN_W = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic neg,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic done,
	output logic signed [NUM_W:0] quot
);
	localparam int CW = $clog2(NUM_W + 1);
	logic [NUM_W-1:0] q_q;
	logic [DEN_W:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, neg_q;
	logic [DEN_W+1:0] trial;

	assign trial = {rem_q, q_q[NUM_W-1]} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			rem_q <= '0;
			den_q <= den;
			neg_q <= neg;
		end else if (busy_q) begin
			if (!trial[DEN_W+1]) begin
				rem_q <= trial[DEN_W:0];
				q_q <= {q_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DEN_W-1:0], q_q[NUM_W-1]};
				q_q <= {q_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quot = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
endmodule

@@ rtl/isc_regs.sv @@
//------------------------------------------------------------------------------
// isc_regs
// APB register file holding gains, tick counts and the garage threshold.
//------------------------------------------------------------------------------
module isc_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [isc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output isc_pkg::cfg_t cfg
);
	import isc_pkg::*;
	reg_idx_t idx;
	logic hit;
	assign idx = reg_idx_t'(paddr[4:2]);
	assign hit = (paddr[1:0] == 2'b00);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg <= '{main_p: '0, main_d: '0, round_p: '0, round_d: '0, turn: '0,
				freeze: '0, down: '0, garage: 14'd1500};
		end else if (psel && penable && pwrite && hit) begin
			unique case (idx)
				REG_MAIN_P: cfg.main_p <= pwdata[15:0];
				REG_MAIN_D: cfg.main_d <= pwdata[15:0];
				REG_ROUND_P: cfg.round_p <= pwdata[15:0];
				REG_ROUND_D: cfg.round_d <= pwdata[15:0];
				REG_TURN: cfg.turn <= pwdata[15:0];
				REG_FREEZE: cfg.freeze <= pwdata[15:0];
				REG_DOWN: cfg.down <= pwdata[15:0];
				REG_GARAGE: cfg.garage <= pwdata[13:0];
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			unique case (idx)
				REG_MAIN_P: prdata = {16'd0, cfg.main_p};
				REG_MAIN_D: prdata = {16'd0, cfg.main_d};
				REG_ROUND_P: prdata = {16'd0, cfg.round_p};
				REG_ROUND_D: prdata = {16'd0, cfg.round_d};
				REG_TURN: prdata = {16'd0, cfg.turn};
				REG_FREEZE: prdata = {16'd0, cfg.freeze};
				REG_DOWN: prdata = {16'd0, cfg.down};
				REG_GARAGE: prdata = {18'd0, cfg.garage};
			endcase
		end
	end
endmodule

@@ dv/inductive_steering_pd_controller_core_tb.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// inductive_steering_pd_controller_core_tb
// Drives tick readings into the steering core, predicts each steering result in
// a cycle-free model of the controller and compares every field of every result.
//------------------------------------------------------------------------------
module inductive_steering_pd_controller_core_tb;
	import isc_pkg::*;

	localparam int LIMIT = 3000000;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	isc_if #(.payload_t(in_item_t)) in_ch ();
	isc_if #(.payload_t(out_item_t)) out_ch ();

	inductive_steering_pd_controller_core dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Controller mirror: registers and tick state.
	int unsigned cfg [NUM_REGS];
	int hist_h [4];
	int hist_v [4];
	int unsigned garage_stage, round_flag, leave_flag;
	int unsigned turn_left, freeze_left, down_left, blink_div;
	logic [2:0] lamps;

	in_item_t pending_ticks [$];
	out_item_t expected_steer [$];
	int n_queued, n_taken;
	int send_idle, recv_stall;
	bit in_taken;
	bit failed;
	longint cycles;

	function automatic int scale_reading(int unsigned v);
		if (v < 10) v = 10;
		return int'((v * 9) / 10);
	endfunction

	function automatic int pair_error(int a, int b);
		longint num, den;
		num = longint'(a - b) * 16384;
		den = longint'(a) + longint'(b);
		return int'(num / den);
	endfunction

	function automatic int clamp_deriv(int newest, int oldest);
		longint d;
		d = 5 * (longint'(newest) - longint'(oldest));
		if (d > 11468) d = 11468;
		if (d < -11468) d = -11468;
		return int'(d);
	endfunction

	function automatic out_item_t steer_tick(in_item_t it);
		int unsigned r0, r1, r2, r3, vsum;
		int s0, s1, s2, s3, eh, ev, dh, dv;
		bit stop;
		longint acc, drive;
		out_item_t o;
		r0 = 32'(it.sense_h_left);
		r1 = 32'(it.sense_h_right);
		r2 = 32'(it.sense_v_left);
		r3 = 32'(it.sense_v_right);
		vsum = r2 + r3;
		stop = (r0 < 300 && r1 < 300 && garage_stage > 1);
		if (vsum < cfg[REG_GARAGE] && vsum > 25 && garage_stage == 0) begin
			garage_stage = 1;
			lamps[0] = 1'b1;
		end
		if (r0 > 1000 && r1 > 1000 && garage_stage == 1) begin
			garage_stage = 2;
			lamps[0] = 1'b0;
		end
		s0 = scale_reading(r0);
		s1 = scale_reading(r1);
		s2 = scale_reading(r2);
		s3 = scale_reading(r3);
		eh = pair_error(s0, s1);
		ev = pair_error(s2, s3);
		for (int i = 3; i > 0; i--) begin
			hist_h[i] = hist_h[i-1];
			hist_v[i] = hist_v[i-1];
		end
		hist_h[0] = eh;
		hist_v[0] = ev;
		dh = clamp_deriv(hist_h[0], hist_h[3]);
		dv = clamp_deriv(hist_v[0], hist_v[3]);

		// Entry takes priority; an entry seen while leave is pending does nothing.
		if (s0 > 2000 && s1 > 2000 && (s2 > 1200 || s3 > 1200) && freeze_left == 0) begin
			if (!leave_flag) begin
				round_flag = 1;
				leave_flag = 1;
				lamps[1] = 1'b1;
				turn_left = cfg[REG_TURN];
				freeze_left = cfg[REG_FREEZE];
			end
		end else if (s0 > 1300 && s1 > 1300 && (s2 > 1000 || s3 > 1000) && freeze_left == 0) begin
			if (leave_flag) begin
				leave_flag = 0;
				lamps[2] = 1'b1;
				freeze_left = cfg[REG_FREEZE];
			end
		end
		if (s0 < 2000 && s1 < 2000 && s2 > 1000 && s3 > 1000 &&
		    down_left == 0 && freeze_left == 0 && !leave_flag)
			down_left = cfg[REG_DOWN];
		if (down_left != 0) begin
			if (blink_div != 0) begin
				blink_div--;
			end else begin
				blink_div = 30;
				lamps[2] = ~lamps[2];
			end
			down_left--;
			if (down_left == 0) lamps[2] = 1'b0;
		end
		if (freeze_left != 0) begin
			freeze_left--;
			if (freeze_left == 0) lamps[2:1] = 2'b00;
		end
		if (turn_left != 0) begin
			turn_left--;
			if (turn_left == 0) round_flag = 0;
		end
		if (round_flag)
			acc = longint'(ev) * longint'(cfg[REG_ROUND_P])
				+ longint'(dv) * longint'(cfg[REG_ROUND_D]);
		else
			acc = longint'(eh) * longint'(cfg[REG_MAIN_P])
				+ longint'(dh) * longint'(cfg[REG_MAIN_D]);
		drive = acc >>> 14;
		if (drive > 131071) drive = 131071;
		if (drive < -131072) drive = -131072;
		o.steer_drive = drive[DRIVE_W-1:0];
		o.round_active = round_flag[0];
		o.leave_pending = leave_flag[0];
		o.stop_request = stop;
		o.garage_lamp = lamps[0];
		o.green_lamp = lamps[1];
		o.red_lamp = lamps[2];
		return o;
	endfunction

	function automatic in_item_t make_tick(int hl, int hr, int vl, int vr);
		in_item_t t;
		t.sense_h_left = SENSE_W'(hl);
		t.sense_h_right = SENSE_W'(hr);
		t.sense_v_left = SENSE_W'(vl);
		t.sense_v_right = SENSE_W'(vr);
		return t;
	endfunction

	// Mostly road situations that drive the mode logic, the rest plain noise.
	function automatic in_item_t random_tick();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			return make_tick($urandom_range(0, 8191), $urandom_range(0, 8191),
				$urandom_range(0, 8191), $urandom_range(0, 8191));
		if (pick < 45)
			return make_tick($urandom_range(2224, 8191), $urandom_range(2224, 8191),
				$urandom_range(1335, 8191), $urandom_range(0, 8191));
		if (pick < 65)
			return make_tick($urandom_range(1445, 2223), $urandom_range(1445, 2223),
				$urandom_range(0, 8191), $urandom_range(1112, 8191));
		if (pick < 80)
			return make_tick($urandom_range(0, 2222), $urandom_range(0, 2222),
				$urandom_range(1112, 8191), $urandom_range(1112, 8191));
		if (pick < 90)
			return make_tick($urandom_range(0, 8191), $urandom_range(0, 8191),
				$urandom_range(0, 800), $urandom_range(0, 800));
		return make_tick($urandom_range(0, 299), $urandom_range(0, 299),
			$urandom_range(0, 8191), $urandom_range(0, 8191));
	endfunction

	task automatic queue_tick(in_item_t t);
		pending_ticks.push_back(t);
		n_queued++;
	endtask

	task automatic write_reg(reg_idx_t idx, int unsigned value);
		logic [31:0] wide;
		// Upper bits carry noise; only the register width is kept.
		wide = {16'($urandom_range(0, 65535)), 16'h0} | value;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= wide;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		cfg[idx] = (idx == REG_GARAGE) ? (wide & 32'h3FFF) : (wide & 32'hFFFF);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		wait (n_taken == n_queued && expected_steer.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_all(int unsigned mp, int unsigned md, int unsigned rp,
		int unsigned rd, int unsigned tt, int unsigned ft, int unsigned dt, int unsigned gt);
		write_reg(REG_MAIN_P, mp);
		write_reg(REG_MAIN_D, md);
		write_reg(REG_ROUND_P, rp);
		write_reg(REG_ROUND_D, rd);
		write_reg(REG_TURN, tt);
		write_reg(REG_FREEZE, ft);
		write_reg(REG_DOWN, dt);
		write_reg(REG_GARAGE, gt);
	endtask

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("inductive_steering_pd_controller_core_tb: done, errors");
			$finish;
		end
	end

	// Driver: new readings and receiver stalls change at the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_ch.valid || in_taken) begin
				if (pending_ticks.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
					in_ch.data <= pending_ticks.pop_front();
					in_ch.valid <= 1'b1;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
			out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
		end
	end

	// Monitor: predict on each accepted tick, compare each returned result.
	always @(posedge clk) begin
		out_item_t want, got;
		in_taken = in_ch.valid && in_ch.ready;
		if (in_taken) begin
			expected_steer.push_back(steer_tick(in_ch.data));
			n_taken++;
		end
		if (out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (expected_steer.size() == 0) begin
				$error("unexpected result transaction: steer_drive %0d", got.steer_drive);
				failed = 1'b1;
			end else begin
				want = expected_steer.pop_front();
				if (got.steer_drive !== want.steer_drive) begin
					$error("steer_drive expected %0d actual %0d", want.steer_drive, got.steer_drive);
					failed = 1'b1;
				end
				if (got.round_active !== want.round_active) begin
					$error("round_active expected %0b actual %0b", want.round_active, got.round_active);
					failed = 1'b1;
				end
				if (got.leave_pending !== want.leave_pending) begin
					$error("leave_pending expected %0b actual %0b", want.leave_pending,
						got.leave_pending);
					failed = 1'b1;
				end
				if (got.stop_request !== want.stop_request) begin
					$error("stop_request expected %0b actual %0b", want.stop_request, got.stop_request);
					failed = 1'b1;
				end
				if (got.garage_lamp !== want.garage_lamp) begin
					$error("garage_lamp expected %0b actual %0b", want.garage_lamp, got.garage_lamp);
					failed = 1'b1;
				end
				if (got.green_lamp !== want.green_lamp) begin
					$error("green_lamp expected %0b actual %0b", want.green_lamp, got.green_lamp);
					failed = 1'b1;
				end
				if (got.red_lamp !== want.red_lamp) begin
					$error("red_lamp expected %0b actual %0b", want.red_lamp, got.red_lamp);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		cycles = 0;
		failed = 1'b0;
		in_taken = 1'b0;
		n_queued = 0;
		n_taken = 0;
		send_idle = 0;
		recv_stall = 0;
		for (int i = 0; i < NUM_REGS; i++) cfg[i] = 0;
		cfg[REG_GARAGE] = 1500;
		for (int i = 0; i < 4; i++) begin
			hist_h[i] = 0;
			hist_v[i] = 0;
		end
		garage_stage = 0;
		round_flag = 0;
		leave_flag = 0;
		turn_left = 0;
		freeze_left = 0;
		down_left = 100;
		blink_div = 0;
		lamps = 3'b000;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed ticks: field extremes, garage exit then stop, roundabout entry,
		// repeated entry while leave is pending, leave, and the downhill window.
		write_all(16'h0180, 16'h0040, 16'h0200, 16'h0080, 3, 2, 5, 1500);
		queue_tick(make_tick(0, 0, 0, 0));
		queue_tick(make_tick(8191, 8191, 8191, 8191));
		queue_tick(make_tick(8191, 0, 0, 8191));
		queue_tick(make_tick(5, 9, 10, 11));
		queue_tick(make_tick(100, 200, 12, 13));
		queue_tick(make_tick(100, 200, 13, 13));
		queue_tick(make_tick(1001, 1001, 700, 799));
		queue_tick(make_tick(299, 299, 50, 60));
		queue_tick(make_tick(300, 299, 50, 60));
		queue_tick(make_tick(2224, 2224, 1335, 0));
		queue_tick(make_tick(3000, 3000, 2000, 100));
		queue_tick(make_tick(2223, 2224, 1335, 1335));
		queue_tick(make_tick(1600, 1600, 1200, 1200));
		queue_tick(make_tick(1446, 1446, 0, 1112));
		queue_tick(make_tick(1600, 1600, 1200, 1200));
		queue_tick(make_tick(2222, 2222, 1112, 1112));
		for (int i = 0; i < 6; i++) queue_tick(make_tick(500, 400, 1500, 1500));
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: write_all(65535, 65535, 65535, 65535, 0, 0, 0, 16383);
				2: write_all(0, 0, 0, 0, 1, 1, 1, 0);
				4: write_all($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535), 65535, 65535, 65535,
					$urandom_range(0, 16383));
				default: write_all($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 12),
					$urandom_range(0, 8), $urandom_range(0, 40), $urandom_range(0, 16383));
			endcase
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 71; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 71; end
				default: begin send_idle = 23; recv_stall = 23; end
			endcase
			for (int i = 0; i < 150; i++) queue_tick(random_tick());
			drain();
		end

		if (!failed)
			$display("inductive_steering_pd_controller_core_tb: done, clean");
		else
			$display("inductive_steering_pd_controller_core_tb: done, errors");
		$finish;
	end
endmodule
